// ===== design/ctdrm_pkg.sv =====
// shared types and constants of the two-drive receive monitor
package ctdrm_pkg;

  typedef enum logic [1:0] {
    KindFrame = 2'd0,
    KindTick  = 2'd1,
    KindClear = 2'd2,
    KindNop   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    MsgHeartbeat = 3'd0,
    MsgSdo       = 3'd1,
    MsgTpdo1     = 3'd2,
    MsgTpdo2     = 3'd3,
    MsgNone      = 3'd4
  } msg_e;

  typedef enum logic [2:0] {
    StTick      = 3'd0,
    StHandled   = 3'd1,
    StDropStale = 3'd2,
    StDropNop   = 3'd3,
    StUnknown   = 3'd4,
    StSdoAbort  = 3'd5,
    StCleared   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    DrvInit       = 3'd0,
    DrvDisabled   = 3'd1,
    DrvReady      = 3'd2,
    DrvSwitchedOn = 3'd3,
    DrvEnabled    = 3'd4,
    DrvUnknown    = 3'd5
  } drive_e;

  localparam logic [1:0] RegFirstId  = 2'd0;
  localparam logic [1:0] RegSecondId = 2'd1;
  localparam logic [1:0] RegHbLimit  = 2'd2;

  localparam logic [11:0] SdoReplyBase  = 12'h580;
  localparam logic [11:0] Tpdo1Base     = 12'h180;
  localparam logic [11:0] Tpdo2Base     = 12'h280;
  localparam logic [11:0] HeartbeatBase = 12'h700;

  localparam logic [7:0] NmtStopped  = 8'h04;
  localparam logic [7:0] NmtPreop    = 8'h7F;
  localparam logic [7:0] SdoAbortCmd = 8'h80;
  localparam logic [7:0] CwReady     = 8'h31;
  localparam logic [7:0] CwSwitchOn  = 8'h33;
  localparam logic [7:0] CwEnabled   = 8'h37;
  localparam logic [7:0] CwDisabled  = 8'h70;
  localparam int unsigned ReachedBit = 2;

  localparam logic [15:0] AgeMax = 16'hFFFF;

  typedef struct packed {
    kind_e       kind;
    msg_e        msg;
    logic        match_node;
    logic        target_node;
    logic        len_one;
    drive_e      drive;
    logic        reach_set;
    logic        sdo_abort;
    logic [63:0] payload;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic        node;
    logic [31:0] speed;
    logic [31:0] position;
    drive_e      drive;
    logic        reached;
    logic [7:0]  nmt;
    logic        alarm;
    logic [31:0] abort_code;
  } result_t;

  function automatic drive_e decode_drive(input logic [7:0] b);
    drive_e d;
    unique case (b)
      CwReady:    d = DrvReady;
      CwSwitchOn: d = DrvSwitchedOn;
      CwEnabled:  d = DrvEnabled;
      CwDisabled: d = DrvDisabled;
      default:    d = DrvUnknown;
    endcase
    return d;
  endfunction

endpackage

// ===== design/ctdrm_fifo.sv =====
// small first-in first-out queue of packed words
module ctdrm_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             rd_i,
  output logic             full_o,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/ctdrm_front.sv =====
// front end: identifier masking, node and message matching, payload decode
module ctdrm_front (
  input  logic [1:0]       kind_i,
  input  logic [28:0]      frame_id_i,
  input  logic             is_extended_i,
  input  logic [3:0]       data_length_i,
  input  logic [63:0]      payload_i,
  input  logic             target_node_i,
  input  logic [6:0]       first_id_i,
  input  logic [6:0]       second_id_i,
  output ctdrm_pkg::item_t item_o
);

  logic [28:0] id;
  logic [3:0]  hit0, hit1;
  logic [28:0] bases [4];

  assign id = is_extended_i ? frame_id_i : {18'd0, frame_id_i[10:0]};

  assign bases[0] = 29'(ctdrm_pkg::HeartbeatBase);
  assign bases[1] = 29'(ctdrm_pkg::SdoReplyBase);
  assign bases[2] = 29'(ctdrm_pkg::Tpdo1Base);
  assign bases[3] = 29'(ctdrm_pkg::Tpdo2Base);

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      hit0[t] = (id == bases[t] + 29'(first_id_i));
      hit1[t] = (id == bases[t] + 29'(second_id_i));
    end
  end

  always_comb begin
    item_o             = '0;
    item_o.kind        = ctdrm_pkg::kind_e'(kind_i);
    item_o.target_node = target_node_i;
    item_o.len_one     = (data_length_i == 4'd1);
    item_o.payload     = payload_i;
    item_o.drive       = ctdrm_pkg::decode_drive(payload_i[7:0]);
    item_o.reach_set   = payload_i[8 + ctdrm_pkg::ReachedBit];
    item_o.sdo_abort   = (payload_i[7:0] == ctdrm_pkg::SdoAbortCmd);
    item_o.match_node  = 1'b0;
    item_o.msg         = ctdrm_pkg::MsgNone;
    priority if (hit0 != '0) begin
      item_o.match_node = 1'b0;
      priority if (hit0[0]) item_o.msg = ctdrm_pkg::MsgHeartbeat;
      else if (hit0[1])     item_o.msg = ctdrm_pkg::MsgSdo;
      else if (hit0[2])     item_o.msg = ctdrm_pkg::MsgTpdo1;
      else                  item_o.msg = ctdrm_pkg::MsgTpdo2;
    end else if (hit1 != '0) begin
      item_o.match_node = 1'b1;
      priority if (hit1[0]) item_o.msg = ctdrm_pkg::MsgHeartbeat;
      else if (hit1[1])     item_o.msg = ctdrm_pkg::MsgSdo;
      else if (hit1[2])     item_o.msg = ctdrm_pkg::MsgTpdo1;
      else                  item_o.msg = ctdrm_pkg::MsgTpdo2;
    end else begin
      item_o.match_node = 1'b0;
      item_o.msg        = ctdrm_pkg::MsgNone;
    end
  end

endmodule

// ===== design/ctdrm_back.sv =====
// back end: per-node drive state, gating, heartbeat ages and result build
module ctdrm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ctdrm_pkg::item_t   item_i,
  input  logic               res_full_i,
  input  logic [15:0]        hb_limit_i,
  output logic               take_o,
  output ctdrm_pkg::result_t result_o
);

  logic [31:0]       speed_q [2], speed_d [2];
  logic [31:0]       pos_q [2], pos_d [2];
  ctdrm_pkg::drive_e drive_q [2], drive_d [2];
  logic [1:0]        reached_q, reached_d;
  logic [7:0]        nmt_q [2], nmt_d [2];
  logic [15:0]       age_q [2], age_d [2];

  logic stale_now, nmt_bad, rnode;
  ctdrm_pkg::status_e status;
  logic [31:0] abort_code;

  assign take_o = valid_i && !res_full_i;

  assign stale_now = (age_q[0] >= hb_limit_i) || (age_q[1] >= hb_limit_i);
  assign nmt_bad   = (nmt_q[0] == ctdrm_pkg::NmtStopped) || (nmt_q[0] == ctdrm_pkg::NmtPreop) ||
                     (nmt_q[1] == ctdrm_pkg::NmtStopped) || (nmt_q[1] == ctdrm_pkg::NmtPreop);

  always_comb begin
    speed_d    = speed_q;
    pos_d      = pos_q;
    drive_d    = drive_q;
    reached_d  = reached_q;
    nmt_d      = nmt_q;
    age_d      = age_q;
    rnode      = item_i.target_node;
    status     = ctdrm_pkg::StTick;
    abort_code = '0;
    unique case (item_i.kind)
      ctdrm_pkg::KindTick: begin
        for (int n = 0; n < 2; n++) begin
          if (age_q[n] != ctdrm_pkg::AgeMax) age_d[n] = age_q[n] + 16'd1;
        end
      end
      ctdrm_pkg::KindClear: begin
        reached_d[item_i.target_node] = 1'b0;
        status = ctdrm_pkg::StCleared;
      end
      ctdrm_pkg::KindFrame: begin
        priority if (item_i.msg == ctdrm_pkg::MsgHeartbeat) begin
          rnode  = item_i.match_node;
          status = ctdrm_pkg::StHandled;
          if (item_i.len_one) begin
            age_d[item_i.match_node] = '0;
            nmt_d[item_i.match_node] = item_i.payload[7:0];
          end
        end else if (stale_now) begin
          status = ctdrm_pkg::StDropStale;
        end else if (nmt_bad) begin
          status = ctdrm_pkg::StDropNop;
        end else if (item_i.msg == ctdrm_pkg::MsgNone) begin
          status = ctdrm_pkg::StUnknown;
        end else begin
          rnode  = item_i.match_node;
          status = ctdrm_pkg::StHandled;
          unique case (item_i.msg)
            ctdrm_pkg::MsgSdo: begin
              if (item_i.sdo_abort) begin
                status     = ctdrm_pkg::StSdoAbort;
                abort_code = item_i.payload[63:32];
              end
            end
            ctdrm_pkg::MsgTpdo1: begin
              speed_d[item_i.match_node] = item_i.payload[31:0];
              pos_d[item_i.match_node]   = item_i.payload[63:32];
            end
            ctdrm_pkg::MsgTpdo2: begin
              drive_d[item_i.match_node] = item_i.drive;
              if (item_i.reach_set) reached_d[item_i.match_node] = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o.status     = status;
    result_o.node       = rnode;
    result_o.speed      = speed_d[rnode];
    result_o.position   = pos_d[rnode];
    result_o.drive      = drive_d[rnode];
    result_o.reached    = reached_d[rnode];
    result_o.nmt        = nmt_d[rnode];
    result_o.alarm      = (age_d[0] >= hb_limit_i) || (age_d[1] >= hb_limit_i);
    result_o.abort_code = abort_code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < 2; n++) begin
        speed_q[n] <= '0;
        pos_q[n]   <= '0;
        drive_q[n] <= ctdrm_pkg::DrvInit;
        nmt_q[n]   <= '0;
        age_q[n]   <= '0;
      end
      reached_q <= 2'b11;
    end else if (take_o) begin
      speed_q   <= speed_d;
      pos_q     <= pos_d;
      drive_q   <= drive_d;
      reached_q <= reached_d;
      nmt_q     <= nmt_d;
      age_q     <= age_d;
    end
  end

endmodule

// ===== design/canopen_two_drive_rx_monitor.sv =====
// top level of the two-drive receive monitor
// Takes one word per cycle (frame, tick, flag clear or no-op) for two servo
// drives while the item queue is not full. A front end masks and matches the
// identifier and decodes the payload; an item queue of QueueDepth words feeds
// the back end, which holds the per-node state and builds one result per word
// into a result queue of QueueDepth words that drives the result ports. Steady
// throughput is one word per clock while the result queue is not full. Registers
// sit at byte addresses 0 (first node id), 4 (second node id) and 8 (heartbeat
// limit); the user must write them only while the block is idle, and the block
// itself does not enforce this.
module canopen_two_drive_rx_monitor #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [28:0] frame_id_i,
  input  logic        is_extended_i,
  input  logic [3:0]  data_length_i,
  input  logic [63:0] payload_i,
  input  logic        target_node_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic        node_o,
  output logic [31:0] speed_o,
  output logic [31:0] position_o,
  output logic [2:0]  drive_state_o,
  output logic        position_reached_o,
  output logic [7:0]  network_state_o,
  output logic        timeout_alarm_o,
  output logic [31:0] abort_code_o
);

  localparam int unsigned ItemW = $bits(ctdrm_pkg::item_t);
  localparam int unsigned ResW  = $bits(ctdrm_pkg::result_t);

  logic [6:0]  first_id_q, second_id_q;
  logic [15:0] hb_limit_q;
  logic        cfg_wr;

  ctdrm_pkg::item_t   front_item, back_item;
  ctdrm_pkg::result_t back_res, head_res;
  logic [ItemW-1:0]   item_word;
  logic [ResW-1:0]    res_word;
  logic               item_empty, take, res_full;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_id_q  <= 7'd1;
      second_id_q <= 7'd2;
      hb_limit_q  <= 16'd2000;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        ctdrm_pkg::RegFirstId:  first_id_q  <= pwdata[6:0];
        ctdrm_pkg::RegSecondId: second_id_q <= pwdata[6:0];
        ctdrm_pkg::RegHbLimit:  hb_limit_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ctdrm_pkg::RegFirstId:  prdata = {25'd0, first_id_q};
      ctdrm_pkg::RegSecondId: prdata = {25'd0, second_id_q};
      ctdrm_pkg::RegHbLimit:  prdata = {16'd0, hb_limit_q};
      default:                prdata = '0;
    endcase
  end

  ctdrm_front u_front (
    .kind_i        (kind_i),
    .frame_id_i    (frame_id_i),
    .is_extended_i (is_extended_i),
    .data_length_i (data_length_i),
    .payload_i     (payload_i),
    .target_node_i (target_node_i),
    .first_id_i    (first_id_q),
    .second_id_i   (second_id_q),
    .item_o        (front_item)
  );

  ctdrm_fifo #(
    .Width (ItemW),
    .Depth (QueueDepth)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_item),
    .rd_i    (take),
    .full_o  (full),
    .empty_o (item_empty),
    .rdata_o (item_word)
  );

  assign back_item = ctdrm_pkg::item_t'(item_word);

  ctdrm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (!item_empty),
    .item_i     (back_item),
    .res_full_i (res_full),
    .hb_limit_i (hb_limit_q),
    .take_o     (take),
    .result_o   (back_res)
  );

  ctdrm_fifo #(
    .Width (ResW),
    .Depth (QueueDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (take),
    .wdata_i (back_res),
    .rd_i    (pop),
    .full_o  (res_full),
    .empty_o (empty),
    .rdata_o (res_word)
  );

  assign head_res           = ctdrm_pkg::result_t'(res_word);
  assign status_o           = head_res.status;
  assign node_o             = head_res.node;
  assign speed_o            = head_res.speed;
  assign position_o         = head_res.position;
  assign drive_state_o      = head_res.drive;
  assign position_reached_o = head_res.reached;
  assign network_state_o    = head_res.nmt;
  assign timeout_alarm_o    = head_res.alarm;
  assign abort_code_o       = head_res.abort_code;

endmodule

// ===== dv/ctdrm_tb_pkg.sv =====
// scoreboard class that predicts and checks the monitor's result words
package ctdrm_tb_pkg;
  import ctdrm_pkg::*;

  class drive_status_board;
    logic [6:0]  first_id;
    logic [6:0]  second_id;
    logic [15:0] hb_limit;
    logic [31:0] speed [2];
    logic [31:0] position [2];
    drive_e      drive [2];
    logic        reached [2];
    logic [7:0]  nmt [2];
    logic [15:0] hb_age [2];
    result_t     expected_reports [$];
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned status_count [7];

    function new();
      first_id      = 7'd1;
      second_id     = 7'd2;
      hb_limit      = 16'd2000;
      mismatches    = 0;
      words_checked = 0;
      for (int n = 0; n < 2; n++) begin
        speed[n]    = '0;
        position[n] = '0;
        drive[n]    = DrvInit;
        reached[n]  = 1'b1;
        nmt[n]      = '0;
        hb_age[n]   = '0;
      end
      for (int s = 0; s < 7; s++) status_count[s] = 0;
    endfunction

    function void complain(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch at word %0d, %s: expected %0h, got %0h",
                 words_checked, what, want, got);
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        RegFirstId:  first_id = val[6:0];
        RegSecondId: second_id = val[6:0];
        RegHbLimit:  hb_limit = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        RegFirstId:  return {25'd0, first_id};
        RegSecondId: return {25'd0, second_id};
        RegHbLimit:  return {16'd0, hb_limit};
        default:     return '0;
      endcase
    endfunction

    function logic stale();
      return hb_age[0] >= hb_limit || hb_age[1] >= hb_limit;
    endfunction

    function logic not_operational();
      return nmt[0] == NmtStopped || nmt[0] == NmtPreop ||
             nmt[1] == NmtStopped || nmt[1] == NmtPreop;
    endfunction

    // node 0 is searched first, so equal node ids resolve to node 0
    function msg_e match_id(input logic [28:0] id, output logic nd);
      logic [6:0] nid;
      nd = 1'b0;
      for (int n = 0; n < 2; n++) begin
        nid = (n == 0) ? first_id : second_id;
        nd  = (n != 0);
        if (id == 29'(HeartbeatBase) + 29'(nid)) return MsgHeartbeat;
        if (id == 29'(SdoReplyBase) + 29'(nid)) return MsgSdo;
        if (id == 29'(Tpdo1Base) + 29'(nid)) return MsgTpdo1;
        if (id == 29'(Tpdo2Base) + 29'(nid)) return MsgTpdo2;
      end
      nd = 1'b0;
      return MsgNone;
    endfunction

    function drive_e drive_from_byte(logic [7:0] b);
      if (b == CwReady) return DrvReady;
      if (b == CwSwitchOn) return DrvSwitchedOn;
      if (b == CwEnabled) return DrvEnabled;
      if (b == CwDisabled) return DrvDisabled;
      return DrvUnknown;
    endfunction

    function void note_word(logic [1:0] kind, logic [28:0] frame_id, logic ext,
                            logic [3:0] dlen, logic [63:0] payload, logic tgt);
      logic [28:0] id;
      logic        sel;
      logic        nd;
      msg_e        msg;
      status_e     st;
      logic [31:0] abort;
      result_t     r;
      id    = ext ? frame_id : {18'd0, frame_id[10:0]};
      sel   = tgt;
      st    = StTick;
      abort = '0;
      case (kind_e'(kind))
        KindTick: begin
          for (int n = 0; n < 2; n++) begin
            if (hb_age[n] != AgeMax) hb_age[n] = hb_age[n] + 16'd1;
          end
        end
        KindClear: begin
          reached[tgt] = 1'b0;
          st = StCleared;
        end
        KindFrame: begin
          msg = match_id(id, nd);
          if (msg == MsgHeartbeat) begin
            sel = nd;
            st  = StHandled;
            if (dlen == 4'd1) begin
              hb_age[nd] = '0;
              nmt[nd]    = payload[7:0];
            end
          end else if (stale()) begin
            st = StDropStale;
          end else if (not_operational()) begin
            st = StDropNop;
          end else if (msg == MsgNone) begin
            st = StUnknown;
          end else begin
            sel = nd;
            st  = StHandled;
            case (msg)
              MsgSdo: begin
                if (payload[7:0] == SdoAbortCmd) begin
                  st    = StSdoAbort;
                  abort = payload[63:32];
                end
              end
              MsgTpdo1: begin
                speed[nd]    = payload[31:0];
                position[nd] = payload[63:32];
              end
              default: begin
                drive[nd] = drive_from_byte(payload[7:0]);
                if (payload[8 + ReachedBit]) reached[nd] = 1'b1;
              end
            endcase
          end
        end
        default: ;
      endcase
      r.status     = st;
      r.node       = sel;
      r.speed      = speed[sel];
      r.position   = position[sel];
      r.drive      = drive[sel];
      r.reached    = reached[sel];
      r.nmt        = nmt[sel];
      r.alarm      = stale();
      r.abort_code = abort;
      expected_reports.push_back(r);
      status_count[st]++;
    endfunction

    function void check_result(result_t act);
      result_t want;
      if (expected_reports.size() == 0) begin
        complain("result with none expected, status", '0, act.status);
        return;
      end
      want = expected_reports.pop_front();
      if (act.status !== want.status) complain("status", want.status, act.status);
      if (act.node !== want.node) complain("node", want.node, act.node);
      if (act.speed !== want.speed) complain("speed", want.speed, act.speed);
      if (act.position !== want.position) complain("position", want.position, act.position);
      if (act.drive !== want.drive) complain("drive state", want.drive, act.drive);
      if (act.reached !== want.reached) complain("position reached", want.reached, act.reached);
      if (act.nmt !== want.nmt) complain("network state", want.nmt, act.nmt);
      if (act.alarm !== want.alarm) complain("timeout alarm", want.alarm, act.alarm);
      if (act.abort_code !== want.abort_code) begin
        complain("abort code", want.abort_code, act.abort_code);
      end
      words_checked++;
    endfunction
  endclass

endpackage

// ===== dv/canopen_two_drive_rx_monitor_tb.sv =====
// testbench top for the two-drive receive monitor
module canopen_two_drive_rx_monitor_tb;
  import ctdrm_pkg::*;
  import ctdrm_tb_pkg::*;

  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned DrainCycles = 10;
  localparam logic [7:0]  NmtOperational = 8'h05;

  typedef struct {
    kind_e       kind;
    logic [28:0] frame_id;
    logic        ext;
    logic [3:0]  dlen;
    logic [63:0] pay;
    logic        tgt;
  } can_word_t;

  typedef enum int {RxSteady, RxCoin, RxSlow} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  kind_i = '0;
  logic [28:0] frame_id_i = '0;
  logic        is_extended_i = 1'b0;
  logic [3:0]  data_length_i = '0;
  logic [63:0] payload_i = '0;
  logic        target_node_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  status_o;
  logic        node_o;
  logic [31:0] speed_o;
  logic [31:0] position_o;
  logic [2:0]  drive_state_o;
  logic        position_reached_o;
  logic [7:0]  network_state_o;
  logic        timeout_alarm_o;
  logic [31:0] abort_code_o;

  drive_status_board board;
  int unsigned cycle_count = 0;
  int unsigned full_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned settings_run = 0;
  int unsigned holds_done = 0;
  bit          hold_req = 1'b0;

  canopen_two_drive_rx_monitor dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .push              (push),
    .full              (full),
    .kind_i            (kind_i),
    .frame_id_i        (frame_id_i),
    .is_extended_i     (is_extended_i),
    .data_length_i     (data_length_i),
    .payload_i         (payload_i),
    .target_node_i     (target_node_i),
    .empty             (empty),
    .pop               (pop),
    .status_o          (status_o),
    .node_o            (node_o),
    .speed_o           (speed_o),
    .position_o        (position_o),
    .drive_state_o     (drive_state_o),
    .position_reached_o(position_reached_o),
    .network_state_o   (network_state_o),
    .timeout_alarm_o   (timeout_alarm_o),
    .abort_code_o      (abort_code_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin : watch_ports
    result_t got;
    if (rst_ni && pop && !empty) begin
      got.status     = status_e'(status_o);
      got.node       = node_o;
      got.speed      = speed_o;
      got.position   = position_o;
      got.drive      = drive_e'(drive_state_o);
      got.reached    = position_reached_o;
      got.nmt        = network_state_o;
      got.alarm      = timeout_alarm_o;
      got.abort_code = abort_code_o;
      board.check_result(got);
    end
    if (rst_ni && push && !full) begin
      board.note_word(kind_i, frame_id_i, is_extended_i, data_length_i, payload_i,
                      target_node_i);
    end
    if (rst_ni && push && full) full_cycles++;
  end

  // result side: random pop patterns, plus one long hold-off on request
  initial begin : result_side
    rx_mode_e mode;
    int unsigned left;
    mode = RxSteady;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        for (int unsigned c = 0; c < HoldCycles; c++) @(posedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        if (left == 0) begin
          mode = rx_mode_e'($urandom_range(2));
          left = $urandom_range(8, 64);
        end
        left--;
        case (mode)
          RxSteady: pop <= 1'b1;
          RxCoin:   pop <= ($urandom_range(1) == 1);
          default:  pop <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  task automatic offer(input can_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    burst_left--;
    kind_i        <= w.kind;
    frame_id_i    <= w.frame_id;
    is_extended_i <= w.ext;
    data_length_i <= w.dlen;
    payload_i     <= w.pay;
    target_node_i <= w.tgt;
    push          <= 1'b1;
    do @(posedge clk_i); while (full);
  endtask

  task automatic settle();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (board.expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (wr) begin
      board.write_reg(idx, data);
    end else if (prdata !== board.reg_value(idx)) begin
      board.complain("register readback", board.reg_value(idx), prdata);
    end
  endtask

  // upper data bits carry noise to check the register widths
  task automatic configure(input logic [6:0] first, input logic [6:0] second,
                           input logic [15:0] limit);
    settle();
    reg_access(1'b1, RegFirstId, {25'($urandom), first});
    reg_access(1'b1, RegSecondId, {25'($urandom), second});
    reg_access(1'b1, RegHbLimit, {16'($urandom), limit});
    reg_access(1'b0, RegFirstId, '0);
    reg_access(1'b0, RegSecondId, '0);
    reg_access(1'b0, RegHbLimit, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_run++;
  endtask

  function automatic can_word_t frame(input logic [11:0] base, input logic nd,
                                      input logic [3:0] dlen, input logic [63:0] pay);
    can_word_t w;
    logic [6:0] nid;
    nid        = nd ? board.second_id : board.first_id;
    w.kind     = KindFrame;
    w.frame_id = 29'(base) + 29'(nid);
    w.ext      = 1'b0;
    w.dlen     = dlen;
    w.pay      = pay;
    w.tgt      = ~nd;
    return w;
  endfunction

  function automatic can_word_t control(input kind_e k, input logic tgt);
    can_word_t w;
    w.kind     = k;
    w.frame_id = 29'($urandom);
    w.ext      = 1'($urandom);
    w.dlen     = 4'($urandom_range(8));
    w.pay      = {$urandom, $urandom};
    w.tgt      = tgt;
    return w;
  endfunction

  function automatic logic [7:0] pick_nmt();
    case ($urandom_range(9))
      0:       return NmtStopped;
      1:       return NmtPreop;
      2:       return 8'($urandom);
      default: return NmtOperational;
    endcase
  endfunction

  // mostly well-formed traffic to the configured nodes, some noise
  function automatic can_word_t random_word();
    can_word_t   w;
    int unsigned pick;
    logic        nd;
    logic [6:0]  nid;
    logic [11:0] base;
    pick = $urandom_range(99);
    nd   = 1'($urandom);
    nid  = nd ? board.second_id : board.first_id;
    w    = control(KindFrame, 1'($urandom));
    if (pick < 15) begin
      w.kind = KindTick;
    end else if (pick < 20) begin
      w.kind = KindClear;
    end else if (pick < 22) begin
      w.kind = KindNop;
    end else if (pick >= 30) begin
      if (pick < 55) base = HeartbeatBase;
      else if (pick < 65) base = SdoReplyBase;
      else if (pick < 80) base = Tpdo1Base;
      else base = Tpdo2Base;
      w.ext      = ($urandom_range(4) == 0);
      w.frame_id = w.ext ? 29'(base) + 29'(nid) : {18'($urandom), 11'(base + 12'(nid))};
      if (base == HeartbeatBase) begin
        w.dlen     = ($urandom_range(5) == 0) ? 4'($urandom_range(8)) : 4'd1;
        w.pay[7:0] = pick_nmt();
      end else if (base == SdoReplyBase) begin
        if ($urandom_range(1) == 1) w.pay[7:0] = SdoAbortCmd;
      end else if (base == Tpdo2Base) begin
        case ($urandom_range(5))
          0:       w.pay[7:0] = CwReady;
          1:       w.pay[7:0] = CwSwitchOn;
          2:       w.pay[7:0] = CwEnabled;
          3:       w.pay[7:0] = CwDisabled;
          default: ;
        endcase
      end
    end
    return w;
  endfunction

  task automatic phase_words(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) offer(random_word());
  endtask

  task automatic run_directed();
    can_word_t w;
    offer(control(KindTick, 1'b0));
    offer(control(KindNop, 1'b1));
    offer(frame(Tpdo1Base, 1'b0, 4'd8, '1));
    offer(frame(HeartbeatBase, 1'b0, 4'd1, {56'd0, NmtOperational}));
    offer(frame(HeartbeatBase, 1'b1, 4'd1, {56'd0, NmtOperational}));
    offer(frame(HeartbeatBase, 1'b1, 4'd0, {56'd0, NmtStopped}));
    offer(frame(Tpdo1Base, 1'b1, 4'd0, {32'h8000_0000, 32'h7FFF_FFFF}));
    offer(frame(Tpdo2Base, 1'b0, 4'd8, {48'd0, 8'(1 << ReachedBit), CwReady}));
    offer(control(KindClear, 1'b0));
    offer(frame(Tpdo2Base, 1'b0, 4'd8, {48'd0, ~8'(1 << ReachedBit), CwSwitchOn}));
    offer(frame(Tpdo2Base, 1'b1, 4'd8, {48'd0, 8'd0, CwEnabled}));
    offer(frame(Tpdo2Base, 1'b1, 4'd8, {48'd0, 8'd0, CwDisabled}));
    offer(frame(Tpdo2Base, 1'b0, 4'd8, {56'hFF_FFFF_FFFF_FFFF, 8'd0}));
    offer(control(KindClear, 1'b1));
    offer(frame(SdoReplyBase, 1'b0, 4'd8, {32'hDEAD_BEEF, 24'd0, SdoAbortCmd}));
    offer(frame(SdoReplyBase, 1'b1, 4'd8, {56'hFF_FFFF_FFFF_FFFF, 8'h43}));
    w = frame(Tpdo1Base, 1'b0, 4'd8, {$urandom, $urandom});
    w.frame_id = 29'h123;
    offer(w);
    // extended id with the high bits set misses, the same id in base format matches
    w = frame(Tpdo1Base, 1'b0, 4'd8, {$urandom, $urandom});
    w.frame_id[28:11] = '1;
    w.ext = 1'b1;
    offer(w);
    w.ext = 1'b0;
    offer(w);
    offer(frame(HeartbeatBase, 1'b0, 4'd1, {56'd0, NmtPreop}));
    offer(frame(Tpdo1Base, 1'b1, 4'd8, {$urandom, $urandom}));
    offer(frame(HeartbeatBase, 1'b1, 4'd1, {56'd0, NmtStopped}));
    offer(frame(HeartbeatBase, 1'b0, 4'd1, {56'd0, NmtOperational}));
    offer(frame(SdoReplyBase, 1'b0, 4'd8, {32'h1234_5678, 24'd0, SdoAbortCmd}));
    offer(frame(HeartbeatBase, 1'b1, 4'd1, {56'd0, NmtOperational}));
    offer(control(KindTick, 1'b1));
  endtask

  initial begin : stimulus
    board = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();

    configure(7'd127, 7'd1, 16'd1);
    phase_words(60);
    // zero limit keeps both nodes timed out
    configure(7'd64, 7'd64, 16'd0);
    phase_words(30);
    configure(7'd64, 7'd64, 16'd12);
    hold_req = 1'b1;
    burst_left = 150;
    phase_words(70);
    configure(7'($urandom_range(1, 127)), 7'($urandom_range(1, 127)),
              16'($urandom_range(4, 40)));
    phase_words(80);
    // run of ticks under the widest limit
    configure(7'($urandom_range(1, 127)), 7'($urandom_range(1, 127)), 16'hFFFF);
    for (int unsigned i = 0; i < 40; i++) offer(control(KindTick, 1'($urandom)));
    phase_words(40);
    configure(7'd1, 7'd2, 16'd2000);
    phase_words(80);

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("checked %0d words: %0d ticks, %0d handled, %0d stale drops, %0d state drops,",
             board.words_checked, board.status_count[StTick], board.status_count[StHandled],
             board.status_count[StDropStale], board.status_count[StDropNop]);
    $display("%0d unknown ids, %0d sdo aborts, %0d clears; %0d settings, %0d full cycles, %0d holds",
             board.status_count[StUnknown], board.status_count[StSdoAbort],
             board.status_count[StCleared], settings_run, full_cycles, holds_done);
    if (board.mismatches == 0 && board.expected_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
